// ----- sv/sfe_pkg.sv -----
// Shared types and constants for the sample frame encoder.
// No dependencies; all other files refer to it by scoped names.
`default_nettype none

package sfe_pkg;

  localparam int unsigned BODY_BYTES  = 9;
  localparam int unsigned FRAME_BYTES = 11;
  localparam int unsigned BODY_W      = BODY_BYTES * 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] REG_START_MARKER  = 2'd0;
  localparam logic [1:0] REG_STABLE_CODE   = 2'd1;
  localparam logic [1:0] REG_UNSTABLE_CODE = 2'd2;

  typedef struct packed {
    logic [7:0]         chan;
    logic               is_stable;
    logic signed [31:0] sample_value;
    logic [15:0]        seq_num;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_word_t;

  // nine frame bytes ahead of the CRC, byte 0 in the top bits
  typedef logic [BODY_W-1:0] body_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- sv/sfe_front.sv -----
// Front end: configuration registers, accepts words and assembles frame bodies.
// Depends on sfe_pkg.
`default_nettype none

module sfe_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data,
  input  wire logic             start,
  input  wire sfe_pkg::in_word_t item,
  input  wire sfe_pkg::q_stat_t q_stat,
  output logic                  busy,
  output logic                  push,
  output sfe_pkg::body_t        body
);

  logic [7:0] start_marker;
  logic [7:0] stable_code;
  logic [7:0] unstable_code;
  logic [7:0] flag_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker  <= 8'd170;
      stable_code   <= 8'd1;
      unstable_code <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfe_pkg::REG_START_MARKER:  start_marker  <= cfg_data;
        sfe_pkg::REG_STABLE_CODE:   stable_code   <= cfg_data;
        sfe_pkg::REG_UNSTABLE_CODE: unstable_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign flag_byte = item.is_stable ? stable_code : unstable_code;
  assign busy      = q_stat.full;
  assign push      = start && !q_stat.full;
  assign body      = {start_marker, item.chan, flag_byte,
                      item.sample_value, item.seq_num};

endmodule

`default_nettype wire

// ----- sv/sfe_queue.sv -----
// Two-entry queue of frame bodies between front and back ends.
// Depends on sfe_pkg.
`default_nettype none

module sfe_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire sfe_pkg::body_t push_body,
  input  wire logic       pop,
  output sfe_pkg::body_t  head,
  output sfe_pkg::q_stat_t stat
);

  sfe_pkg::body_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign do_pop     = pop && (count != 2'd0);
  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_body;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/sfe_back.sv -----
// Back end: shifts out frame bytes, runs CRC-16 a byte per cycle, appends it.
// Depends on sfe_pkg.
`default_nettype none

module sfe_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sfe_pkg::body_t   head,
  input  wire sfe_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             active,
  output logic             result_valid,
  output sfe_pkg::out_word_t result
);

  sfe_pkg::body_t shreg;
  logic [3:0]     idx;
  logic [15:0]    crc;
  logic           take;
  logic [7:0]     cur_byte;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] acc;
    acc = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      acc = acc[15] ? ({acc[14:0], 1'b0} ^ sfe_pkg::CRC_POLY) : {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  assign pop      = !active || (idx == 4'(sfe_pkg::FRAME_BYTES - 1));
  assign take     = pop && !q_stat.empty;
  assign cur_byte = shreg[sfe_pkg::BODY_W-1 -: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 4'd0;
    end else if (take) begin
      active <= 1'b1;
      idx    <= 4'd0;
    end else if (active) begin
      active <= (idx != 4'(sfe_pkg::FRAME_BYTES - 1));
      idx    <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      shreg <= head;
      crc   <= sfe_pkg::CRC_INIT;
    end else if (active) begin
      shreg <= {shreg[sfe_pkg::BODY_W-9:0], 8'h00};
      if (idx < 4'(sfe_pkg::BODY_BYTES)) begin
        crc <= crc_byte(crc, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (idx < 4'(sfe_pkg::BODY_BYTES)) begin
      result.frame_byte <= cur_byte;
    end else if (idx == 4'(sfe_pkg::BODY_BYTES)) begin
      result.frame_byte <= crc[15:8];
    end else begin
      result.frame_byte <= crc[7:0];
    end
    result.last_byte <= active && (idx == 4'(sfe_pkg::FRAME_BYTES - 1));
  end

endmodule

`default_nettype wire

// ----- sv/sample_frame_encoder_crc16.sv -----
// Top level of the measurement framer with CRC-16/CCITT-FALSE.
// Depends on sfe_pkg, sfe_front, sfe_queue, sfe_back.
//
// Usage:
//   A measurement word on item is taken at a clock edge where start is high
//   and busy is low. Each word becomes an 11-byte frame on result, one byte
//   per cycle, each byte marked by result_valid for one cycle; last_byte
//   flags the CRC low byte. The receiver cannot stall the output.
//   When the block is empty, an accepted word is written into the queue,
//   loaded into the serializer and its first byte registered onto result.
//   Queued frames follow back to back: the byte-wide output serializer loads
//   the next frame as it sends a CRC low byte. A two-entry queue sits between
//   the input and the serializer, so busy rises only when two frames wait
//   behind the one being sent.
//   Configuration: cfg_we with cfg_index 0, 1, 2 writes start marker,
//   stable code, unstable code; other indexes are ignored. Write only
//   while idle.
//   Reset (rst, synchronous) empties the queue, stops output and restores
//   the registers to 0xAA, 0x01, 0x00.
`default_nettype none

module sample_frame_encoder_crc16 (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          start,
  output logic               busy,
  input  wire sfe_pkg::in_word_t item,
  output logic               result_valid,
  output sfe_pkg::out_word_t result
);

  sfe_pkg::q_stat_t q_stat;
  sfe_pkg::body_t   push_body;
  sfe_pkg::body_t   head;
  logic             push;
  logic             pop;
  logic             active;

  sfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .item      (item),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .body      (push_body)
  );

  sfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_body (push_body),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  sfe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .active       (active),
    .result_valid (result_valid),
    .result       (result)
  );

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    result.last_byte |-> result_valid)
    else $error("last byte without strobe");

  a_empty_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && q_stat.empty && !active) |-> ##3 result_valid)
    else $error("first byte not taken three edges after accept");

  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> (active && !q_stat.empty))
    else $error("busy while serializer has room");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("output strobe after reset");

endmodule

`default_nettype wire
